// ===== src/scs_pkg.sv =====
// Shared types and constants for the sorted coordinate set.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int FIELD_W = 16;  // width of the coordinate ports
  localparam int TOTAL_W = 9;   // width of the total_cells port

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic cmp;  // compare the broadcast key against the held key
    logic ins;  // open a slot and insert the key
    logic del;  // close the slot holding the key
    logic clr;  // invalidate everything
  } scs_ctrl_t;

endpackage

// ===== src/scs_cell.sv =====
// One cell of the sorted chain: a key, its valid bit and the compare flags.
`timescale 1ns / 1ps

module scs_cell import scs_pkg::*; #(
  parameter int KEY_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scs_ctrl_t        ctrl,
  input  logic [KEY_W-1:0] key_in,
  input  logic             left_lt,
  input  logic             left_valid,
  input  logic [KEY_W-1:0] left_key,
  input  logic             right_valid,
  input  logic [KEY_W-1:0] right_key,
  output logic             lt,
  output logic             eq,
  output logic             valid,
  output logic [KEY_W-1:0] key
);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic             lt_r;
  logic             eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        lt_r <= valid_r && (key_r < key_in);
        eq_r <= valid_r && (key_r == key_in);
      end
      if (ctrl.clr) begin
        valid_r <= 1'b0;
      end else if (ctrl.ins && !lt_r) begin
        // first cell not below the key takes it, the rest shift right
        valid_r <= left_lt ? 1'b1 : left_valid;
      end else if (ctrl.del && !lt_r) begin
        valid_r <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt_r) begin
      key_r <= left_lt ? key_in : left_key;
    end else if (ctrl.del && !lt_r) begin
      key_r <= right_key;
    end
  end

  assign lt    = lt_r;
  assign eq    = eq_r;
  assign valid = valid_r;
  assign key   = key_r;

endmodule

// ===== src/sorted_coordinate_set.sv =====
// Top level: sorted coordinate set built from a chain of compare-and-shift cells.
// out_valid rises after the word passes S_CMP and S_APPLY; S_APPLY waits on a stall.
// One word at a time: accept (S_IDLE), compare in all cells (S_CMP), shift/apply.
// A finished result sits in the output register while the next word is taken.
// Reset (rst_n low, synchronous) empties the set: cell valid bits and count clear
// at once, so no clearing pass is needed and the block is ready right after.
`timescale 1ns / 1ps

module sorted_coordinate_set import scs_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic signed [FIELD_W-1:0] in_cell_x,
  input  logic signed [FIELD_W-1:0] in_cell_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_was_present,
  output logic [TOTAL_W-1:0]        out_total_cells,
  output logic                      out_dropped
);

  localparam int KEY_W = 2 * COORD_BITS;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                state_r;
  kind_t                 kind_r;
  logic [KEY_W-1:0]      key_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  out_valid_r;
  logic                  was_present_r;
  logic                  dropped_r;
  logic                  was_present_nxt;
  logic                  dropped_nxt;

  logic [COORD_BITS-1:0] code_x;
  logic [COORD_BITS-1:0] code_y;
  logic [KEY_W-1:0]      key_nxt;

  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   valid_vec;
  logic [KEY_W-1:0]      key_arr [CAPACITY];

  logic                  hit;
  logic                  full;
  logic                  go;
  logic                  do_ins;
  logic                  do_del;
  scs_ctrl_t             ctrl;

  // Sign-extend or wrap to COORD_BITS, then flip the sign bit for unsigned order.
  generate
    if (COORD_BITS <= FIELD_W) begin : g_trunc
      assign code_x = {~in_cell_x[COORD_BITS-1], in_cell_x[COORD_BITS-2:0]};
      assign code_y = {~in_cell_y[COORD_BITS-1], in_cell_y[COORD_BITS-2:0]};
    end else begin : g_ext
      logic [COORD_BITS-1:0] ext_x;
      logic [COORD_BITS-1:0] ext_y;
      assign ext_x  = {{(COORD_BITS - FIELD_W){in_cell_x[FIELD_W-1]}}, in_cell_x};
      assign ext_y  = {{(COORD_BITS - FIELD_W){in_cell_y[FIELD_W-1]}}, in_cell_y};
      assign code_x = {~ext_x[COORD_BITS-1], ext_x[COORD_BITS-2:0]};
      assign code_y = {~ext_y[COORD_BITS-1], ext_y[COORD_BITS-2:0]};
    end
  endgenerate

  assign key_nxt = {code_y, code_x};

  assign hit  = |eq_vec;
  assign full = (cnt_r == CNT_W'(CAPACITY));
  assign go   = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  assign do_ins = (kind_r == KIND_ADD) && !hit && !full;
  assign do_del = (kind_r == KIND_REMOVE) && hit;

  assign ctrl.cmp = (state_r == S_CMP);
  assign ctrl.ins = go && do_ins;
  assign ctrl.del = go && do_del;
  assign ctrl.clr = go && (kind_r == KIND_CLEAR);

  always_comb begin
    cnt_nxt         = cnt_r;
    was_present_nxt = 1'b0;
    dropped_nxt     = 1'b0;
    unique case (kind_r)
      KIND_ADD: begin
        was_present_nxt = hit;
        dropped_nxt     = !hit && full;
        if (do_ins) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        was_present_nxt = hit;
        if (do_del) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      KIND_QUERY: begin
        was_present_nxt = hit;
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (go) begin
            cnt_r         <= cnt_nxt;
            out_valid_r   <= 1'b1;
            was_present_r <= was_present_nxt;
            dropped_r     <= dropped_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= kind_t'(in_kind);
      key_r  <= key_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic             l_lt;
      logic             l_valid;
      logic [KEY_W-1:0] l_key;
      logic             r_valid;
      logic [KEY_W-1:0] r_key;

      if (i == 0) begin : g_head
        // nothing to the left: the head takes the key when not below it
        assign l_lt    = 1'b1;
        assign l_valid = 1'b0;
        assign l_key   = '0;
      end else begin : g_mid_l
        assign l_lt    = lt_vec[i-1];
        assign l_valid = valid_vec[i-1];
        assign l_key   = key_arr[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_key   = '0;
      end else begin : g_mid_r
        assign r_valid = valid_vec[i+1];
        assign r_key   = key_arr[i+1];
      end

      scs_cell #(
        .KEY_W (KEY_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .key_in      (key_r),
        .left_lt     (l_lt),
        .left_valid  (l_valid),
        .left_key    (l_key),
        .right_valid (r_valid),
        .right_key   (r_key),
        .lt          (lt_vec[i]),
        .eq          (eq_vec[i]),
        .valid       (valid_vec[i]),
        .key         (key_arr[i])
      );
    end
  endgenerate

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_was_present = was_present_r;
  assign out_dropped     = dropped_r;

  generate
    if (CNT_W >= TOTAL_W) begin : g_tot_cut
      assign out_total_cells = cnt_r[TOTAL_W-1:0];
    end else begin : g_tot_ext
      assign out_total_cells = {{(TOTAL_W - CNT_W){1'b0}}, cnt_r};
    end
  endgenerate

endmodule

// ===== src/scs_checker.sv =====
// Port-level checks for the sorted coordinate set, bound to the top level.
`timescale 1ns / 1ps

module scs_checker import scs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_was_present,
  input logic [TOTAL_W-1:0] out_total_cells,
  input logic               out_dropped
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_was_present)
      && $stable(out_total_cells) && $stable(out_dropped))
    else $error("result word changed while stalled");

  // a refused add never reports the cell as present
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_was_present)
    else $error("dropped and was_present both set");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // only one word in flight: no new accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word still in work");

endmodule

bind sorted_coordinate_set scs_checker u_scs_checker (.*);
